[hw/rtl/gwci_pkg.sv]
// Shared types and constants for the grid warp coordinate interpolator.
// Used by the front end, the cell queue, the pixel walker and the top level.
// No dependencies.
`default_nettype none

package gwci_pkg;

    localparam int CELL_SIZE_LOG_DEF = 3;
    localparam int MAX_FRAME_DIM_DEF = 4096;

    localparam int COORD_W   = 32;
    localparam int CELL_POS_W = 9;
    localparam int INDEX_W   = 24;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // one cell, prepared for the walk
    typedef struct packed {
        logic [CELL_POS_W-1:0] col;
        logic [CELL_POS_W-1:0] row;
        logic [COORD_W-1:0]    ul_u;
        logic [COORD_W-1:0]    ul_v;
        logic [COORD_W-1:0]    diff_u;  // right edge minus left edge
        logic [COORD_W-1:0]    diff_v;
        logic [COORD_W-1:0]    sl_u;    // left edge row step
        logic [COORD_W-1:0]    sl_v;
        logic [COORD_W-1:0]    dsl_u;   // right step minus left step
        logic [COORD_W-1:0]    dsl_v;
    } t_cell;

endpackage

`default_nettype wire

[hw/rtl/gwci_front.sv]
// Front end: takes a cell transfer and works out the edge steps.
// Depends on gwci_pkg; feeds gwci_queue.
`default_nettype none

module gwci_front
    import gwci_pkg::*;
#(
    parameter int CELL_SIZE_LOG = CELL_SIZE_LOG_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [CELL_POS_W-1:0] i_cell_col,
    input  wire logic [CELL_POS_W-1:0] i_cell_row,
    input  wire logic [COORD_W-1:0]    i_ul_u,
    input  wire logic [COORD_W-1:0]    i_ul_v,
    input  wire logic [COORD_W-1:0]    i_ur_u,
    input  wire logic [COORD_W-1:0]    i_ur_v,
    input  wire logic [COORD_W-1:0]    i_ll_u,
    input  wire logic [COORD_W-1:0]    i_ll_v,
    input  wire logic [COORD_W-1:0]    i_lr_u,
    input  wire logic [COORD_W-1:0]    i_lr_v,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_cell                      o_cell
);

    logic                  r_v;
    logic [CELL_POS_W-1:0] r_col, r_row;
    logic [COORD_W-1:0]    r_ul_u, r_ul_v, r_diff_u, r_diff_v;
    logic [COORD_W-1:0]    r_sl_u, r_sl_v, r_sr_u, r_sr_v;
    logic                  accept;
    logic [COORD_W-1:0]    dl_u, dl_v, dr_u, dr_v;

    assign o_stall = r_v && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_v && !i_q_full;

    assign dl_u = i_ll_u - i_ul_u;
    assign dl_v = i_ll_v - i_ul_v;
    assign dr_u = i_lr_u - i_ur_u;
    assign dr_v = i_lr_v - i_ur_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col    <= i_cell_col;
            r_row    <= i_cell_row;
            r_ul_u   <= i_ul_u;
            r_ul_v   <= i_ul_v;
            r_diff_u <= i_ur_u - i_ul_u;
            r_diff_v <= i_ur_v - i_ul_v;
            r_sl_u   <= COORD_W'($signed(dl_u) >>> CELL_SIZE_LOG);
            r_sl_v   <= COORD_W'($signed(dl_v) >>> CELL_SIZE_LOG);
            r_sr_u   <= COORD_W'($signed(dr_u) >>> CELL_SIZE_LOG);
            r_sr_v   <= COORD_W'($signed(dr_v) >>> CELL_SIZE_LOG);
        end
    end

    always_comb begin
        o_cell.col    = r_col;
        o_cell.row    = r_row;
        o_cell.ul_u   = r_ul_u;
        o_cell.ul_v   = r_ul_v;
        o_cell.diff_u = r_diff_u;
        o_cell.diff_v = r_diff_v;
        o_cell.sl_u   = r_sl_u;
        o_cell.sl_v   = r_sl_v;
        o_cell.dsl_u  = r_sr_u - r_sl_u;
        o_cell.dsl_v  = r_sr_v - r_sl_v;
    end

endmodule

`default_nettype wire

[hw/rtl/gwci_queue.sv]
// Short cell queue between the front end and the pixel walker.
// Depends on gwci_pkg.
`default_nettype none

module gwci_queue
    import gwci_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cell i_cell,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_cell      o_cell
);

    t_cell               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wp, r_rp;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cell  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cell;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gwci_back.sv]
// Back end: walks a cell pixel by pixel, clamps the source coordinates and
// forms both indices in a three-stage pipeline. Depends on gwci_pkg.
`default_nettype none

module gwci_back
    import gwci_pkg::*;
#(
    parameter int CELL_SIZE_LOG = CELL_SIZE_LOG_DEF,
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire t_cell                  i_cell,
    output logic                        o_pop,
    input  wire logic [$clog2(MAX_FRAME_DIM+1)-1:0] i_width,
    input  wire logic [$clog2(MAX_FRAME_DIM+1)-1:0] i_height,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [INDEX_W-1:0]          o_dest_index,
    output logic [INDEX_W-1:0]          o_src_index,
    output logic                        o_out_of_frame,
    output logic                        o_last
);

    localparam int DW  = $clog2(MAX_FRAME_DIM + 1);
    localparam int CW  = 2 * CELL_SIZE_LOG;
    localparam int PPW = CELL_POS_W + CELL_SIZE_LOG;
    localparam int DPW = PPW + DW + 1;
    localparam int SPW = 2 * DW + 1;

    function automatic logic [DW:0] clamp(input logic [COORD_W-1:0] fx,
                                          input logic [DW-1:0] dim);
        logic [15:0] c;
        logic [DW:0] res;
        c = fx[COORD_W-1:COORD_W-16];
        if (c[15]) begin
            res = {1'b1, {DW{1'b0}}};
        end else if (c[14:0] >= 15'(dim)) begin
            res = {1'b1, dim - 1'b1};
        end else begin
            res = {1'b0, c[DW-1:0]};
        end
        return res;
    endfunction

    logic                  en, take, row_end, last_px;
    logic                  r_busy, r_bv, r_cv;
    logic [CW-1:0]         r_cnt;
    logic [CELL_POS_W-1:0] r_col, r_row;
    logic [COORD_W-1:0]    r_line_u, r_line_v, r_step_u, r_step_v;
    logic [COORD_W-1:0]    r_left_u, r_left_v, r_diff_u, r_diff_v;
    logic [COORD_W-1:0]    r_sl_u, r_sl_v, r_dsl_u, r_dsl_v;
    logic [COORD_W-1:0]    n_left_u, n_left_v, n_diff_u, n_diff_v;
    logic [DW:0]           cl_u, cl_v;
    logic [DW-1:0]         r_b_su, r_b_sv;
    logic                  r_b_flag, r_b_last;
    logic [PPW-1:0]        r_b_drow, r_b_dcol;
    logic [DPW-1:0]        dest_full;
    logic [SPW-1:0]        src_full;

    assign en      = !(r_cv && i_stall);
    assign last_px = &r_cnt;
    assign row_end = &r_cnt[CELL_SIZE_LOG-1:0];
    assign take    = en && i_q_valid && (!r_busy || last_px);
    assign o_pop   = take;

    assign n_left_u = r_left_u + r_sl_u;
    assign n_left_v = r_left_v + r_sl_v;
    assign n_diff_u = r_diff_u + r_dsl_u;
    assign n_diff_v = r_diff_v + r_dsl_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bv   <= 1'b0;
            r_cv   <= 1'b0;
            r_cnt  <= '0;
        end else if (en) begin
            r_cv <= r_bv;
            r_bv <= r_busy;
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_busy <= !last_px;
                r_cnt  <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (take) begin
                r_col    <= i_cell.col;
                r_row    <= i_cell.row;
                r_line_u <= i_cell.ul_u;
                r_line_v <= i_cell.ul_v;
                r_left_u <= i_cell.ul_u;
                r_left_v <= i_cell.ul_v;
                r_diff_u <= i_cell.diff_u;
                r_diff_v <= i_cell.diff_v;
                r_step_u <= COORD_W'($signed(i_cell.diff_u) >>> CELL_SIZE_LOG);
                r_step_v <= COORD_W'($signed(i_cell.diff_v) >>> CELL_SIZE_LOG);
                r_sl_u   <= i_cell.sl_u;
                r_sl_v   <= i_cell.sl_v;
                r_dsl_u  <= i_cell.dsl_u;
                r_dsl_v  <= i_cell.dsl_v;
            end else if (r_busy) begin
                if (row_end) begin
                    r_left_u <= n_left_u;
                    r_left_v <= n_left_v;
                    r_line_u <= n_left_u;
                    r_line_v <= n_left_v;
                    r_diff_u <= n_diff_u;
                    r_diff_v <= n_diff_v;
                    r_step_u <= COORD_W'($signed(n_diff_u) >>> CELL_SIZE_LOG);
                    r_step_v <= COORD_W'($signed(n_diff_v) >>> CELL_SIZE_LOG);
                end else begin
                    r_line_u <= r_line_u + r_step_u;
                    r_line_v <= r_line_v + r_step_v;
                end
            end
        end
    end

    assign cl_u = clamp(r_line_u, i_width);
    assign cl_v = clamp(r_line_v, i_height);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_su   <= cl_u[DW-1:0];
            r_b_sv   <= cl_v[DW-1:0];
            r_b_flag <= cl_u[DW] || cl_v[DW];
            r_b_last <= last_px;
            r_b_drow <= {r_row, r_cnt[CW-1:CELL_SIZE_LOG]};
            r_b_dcol <= {r_col, r_cnt[CELL_SIZE_LOG-1:0]};
        end
    end

    assign dest_full = DPW'(r_b_drow) * DPW'(i_width) + DPW'(r_b_dcol);
    assign src_full  = SPW'(r_b_sv) * SPW'(i_width) + SPW'(r_b_su);

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_dest_index   <= INDEX_W'(dest_full);
            o_src_index    <= INDEX_W'(src_full);
            o_out_of_frame <= r_b_flag;
            o_last         <= r_b_last;
        end
    end

    assign o_valid = r_cv;

endmodule

`default_nettype wire

[hw/rtl/grid_warp_coordinate_interpolator_top.sv]
// Grid warp coordinate interpolator, top level.
// Holds the frame size registers; instantiates gwci_front, gwci_queue and
// gwci_back. Depends on gwci_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one grid cell: its column and
//   row and four corner source coordinates in signed 16.16. Each cell gives
//   an 8x8 block of results on the output channel (o_valid / i_stall) in
//   row-major order, o_last marking the final pixel.
//   Throughput: one result per cycle while the output is not stalled, set
//   by the pixel walker. Up to two prepared cells wait in the queue, so the
//   front end keeps taking cells while the walker is busy.
//   With the walker idle, a cell passes the front register, the queue, the
//   walker, the clamp stage and the address output stage to its first result.
//   A stall on the output freezes the walker and the address pipeline; the
//   front end stalls only once the queue is full.
//   Reset (synchronous, active low) empties the pipeline and sets the frame
//   to 640 x 480. Write the frame size only while the block is idle.
`default_nettype none

module grid_warp_coordinate_interpolator_top
    import gwci_pkg::*;
#(
    parameter int CELL_SIZE_LOG = CELL_SIZE_LOG_DEF,
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [CELL_POS_W-1:0] i_cell_col,
    input  wire logic [CELL_POS_W-1:0] i_cell_row,
    input  wire logic [COORD_W-1:0]    i_ul_u,
    input  wire logic [COORD_W-1:0]    i_ul_v,
    input  wire logic [COORD_W-1:0]    i_ur_u,
    input  wire logic [COORD_W-1:0]    i_ur_v,
    input  wire logic [COORD_W-1:0]    i_ll_u,
    input  wire logic [COORD_W-1:0]    i_ll_v,
    input  wire logic [COORD_W-1:0]    i_lr_u,
    input  wire logic [COORD_W-1:0]    i_lr_v,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [INDEX_W-1:0]         o_dest_index,
    output logic [INDEX_W-1:0]         o_src_index,
    output logic                       o_out_of_frame,
    output logic                       o_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int DW = $clog2(MAX_FRAME_DIM + 1);

    logic [CFG_W-1:0] r_frame_width, r_frame_height;
    logic [DW-1:0]    eff_w, eff_h;
    logic             push, pop, q_full, q_valid;
    t_cell            f_cell, q_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize as the maximum
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = DW'(1);
        end else if (r_frame_width > CFG_W'(MAX_FRAME_DIM)) begin
            eff_w = DW'(MAX_FRAME_DIM);
        end else begin
            eff_w = DW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = DW'(1);
        end else if (r_frame_height > CFG_W'(MAX_FRAME_DIM)) begin
            eff_h = DW'(MAX_FRAME_DIM);
        end else begin
            eff_h = DW'(r_frame_height);
        end
    end

    gwci_front #(
        .CELL_SIZE_LOG(CELL_SIZE_LOG)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cell_col (i_cell_col),
        .i_cell_row (i_cell_row),
        .i_ul_u     (i_ul_u),
        .i_ul_v     (i_ul_v),
        .i_ur_u     (i_ur_u),
        .i_ur_v     (i_ur_v),
        .i_ll_u     (i_ll_u),
        .i_ll_v     (i_ll_v),
        .i_lr_u     (i_lr_u),
        .i_lr_v     (i_lr_v),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cell     (f_cell)
    );

    gwci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (f_cell),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cell  (q_cell)
    );

    gwci_back #(
        .CELL_SIZE_LOG(CELL_SIZE_LOG),
        .MAX_FRAME_DIM(MAX_FRAME_DIM)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_cell         (q_cell),
        .o_pop          (pop),
        .i_width        (eff_w),
        .i_height       (eff_h),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_dest_index   (o_dest_index),
        .o_src_index    (o_src_index),
        .o_out_of_frame (o_out_of_frame),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
